>>> rtl/core/ordlst_pkg.sv
// ============================================================================
// ordlst_pkg: shared types and constants for the ordered list block
// Item layouts, status and operation codes, default parameter values.
// ============================================================================
package ordlst_pkg;

    // default parameter values
    localparam int CAPACITY_DEF      = 16;
    localparam int ID_BITS_DEF       = 16;
    localparam int DURATION_BITS_DEF = 16;

    // fixed field widths of the channels
    localparam int POS_W   = 5;
    localparam int ID_W    = 16;
    localparam int DUR_W   = 16;
    localparam int CNT_O_W = 5;
    localparam int TOTAL_W = 20;
    localparam int IDX_O_W = 4;

    // operation codes
    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_REMOVE = 1'b1
    } t_func;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // input item
    typedef struct packed {
        t_func            func;
        logic [POS_W-1:0] position;
        logic [ID_W-1:0]  item_id;
        logic [DUR_W-1:0] duration;
    } t_in_item;

    // result item
    typedef struct packed {
        t_status            status;
        logic [CNT_O_W-1:0] entry_count;
        logic [TOTAL_W-1:0] total_duration;
        logic [IDX_O_W-1:0] longest_index;
        logic [ID_W-1:0]    longest_id;
        logic [DUR_W-1:0]   longest_duration;
    } t_out_item;

    // engine status toward the top level
    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_eng_stat;

endpackage

>>> rtl/core/ordlst_chan_if.sv
// ============================================================================
// ordlst_chan_if: valid/ready channel
// Carries one item per handshake; source drives valid and data, sink ready.
// ============================================================================
interface ordlst_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/ordlst_engine.sv
// ============================================================================
// ordlst_engine: list storage and edit sequencer
// Entry memory with one write and one read port; insert shifts up, remove
// searches then shifts down, and every operation ends with a longest scan.
// ============================================================================
module ordlst_engine
    import ordlst_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ID_BITS       = ID_BITS_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    input  logic      i_take,
    output t_eng_stat o_stat,
    output t_out_item o_res
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int ENT_W  = ID_BITS + DURATION_BITS;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SHIFT_UP = 7'b0000010,
        S_PUT      = 7'b0000100,
        S_FIND     = 7'b0001000,
        S_SHIFT_DN = 7'b0010000,
        S_SCAN     = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [TOTAL_W-1:0]       r_total, n_total;
    logic [CNT_W-1:0]         r_ptr, n_ptr;
    logic [CNT_W-1:0]         r_pos, n_pos;
    logic [ID_BITS-1:0]       r_id, n_id;
    logic [DURATION_BITS-1:0] r_dur, n_dur;
    t_status                  r_status, n_status;
    logic                     r_mv_valid, n_mv_valid;
    logic [ADDR_W-1:0]        r_mv_dst, n_mv_dst;
    logic                     r_cv, n_cv;
    logic [CNT_W-1:0]         r_cidx, n_cidx;
    logic [ADDR_W-1:0]        r_best_idx, n_best_idx;
    logic [ID_BITS-1:0]       r_best_id, n_best_id;
    logic [DURATION_BITS-1:0] r_best_dur, n_best_dur;

    // entry memory, id in the upper part and duration in the lower part
    logic [ENT_W-1:0]         r_mem [CAPACITY];
    logic [ENT_W-1:0]         r_rd_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ENT_W-1:0]         wr_data;
    logic [ID_BITS-1:0]       rd_id;
    logic [DURATION_BITS-1:0] rd_dur;
    logic [CNT_W-1:0]         last_idx;

    assign rd_id    = r_rd_data[ENT_W-1 -: ID_BITS];
    assign rd_dur   = r_rd_data[DURATION_BITS-1:0];
    assign last_idx = r_count - CNT_W'(1);
    assign rd_addr  = r_ptr[ADDR_W-1:0];

    // write port: a pending move, else the new entry
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_mv_dst;
        wr_data = r_rd_data;
        if (r_mv_valid) begin
            wr_en = 1'b1;
        end else if (r_state == S_PUT) begin
            wr_en   = 1'b1;
            wr_addr = r_pos[ADDR_W-1:0];
            wr_data = {r_id, r_dur};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_total    = r_total;
        n_ptr      = r_ptr;
        n_pos      = r_pos;
        n_id       = r_id;
        n_dur      = r_dur;
        n_status   = r_status;
        n_mv_valid = 1'b0;
        n_mv_dst   = r_mv_dst;
        n_cv       = 1'b0;
        n_cidx     = r_cidx;
        n_best_idx = r_best_idx;
        n_best_id  = r_best_id;
        n_best_dur = r_best_dur;
        rd_en      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_id       = ID_BITS'(i_item.item_id);
                    n_dur      = DURATION_BITS'(i_item.duration);
                    n_ptr      = '0;
                    n_status   = ST_OK;
                    n_best_idx = '0;
                    n_best_id  = '0;
                    n_best_dur = '0;
                    if (i_item.func == FN_INSERT) begin
                        if (CMP_W'(i_item.position) > CMP_W'(r_count)) begin
                            n_status = ST_BADPOS;
                            n_state  = S_SCAN;
                        end else if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_SCAN;
                        end else begin
                            n_pos = CNT_W'(i_item.position);
                            if (CMP_W'(i_item.position) == CMP_W'(r_count)) begin
                                n_state = S_PUT;
                            end else begin
                                n_state = S_SHIFT_UP;
                                n_ptr   = last_idx;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_SCAN;
                        end else begin
                            n_state = S_FIND;
                        end
                    end
                end
            end

            // move entries up one place, from the end down to the position
            S_SHIFT_UP: begin
                rd_en      = 1'b1;
                n_mv_valid = 1'b1;
                n_mv_dst   = ADDR_W'(r_ptr + CNT_W'(1));
                if (r_ptr == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    n_ptr = r_ptr - CNT_W'(1);
                end
            end

            // write the new entry once the last move has landed
            S_PUT: begin
                if (!r_mv_valid) begin
                    n_count = r_count + CNT_W'(1);
                    n_total = r_total + TOTAL_W'(r_dur);
                    n_ptr   = '0;
                    n_state = S_SCAN;
                end
            end

            // search for the first matching identifier
            S_FIND: begin
                if (r_ptr < r_count) begin
                    rd_en  = 1'b1;
                    n_cv   = 1'b1;
                    n_cidx = r_ptr;
                    n_ptr  = r_ptr + CNT_W'(1);
                end
                if (r_cv) begin
                    if (rd_id == r_id) begin
                        n_cv    = 1'b0;
                        n_total = r_total - TOTAL_W'(rd_dur);
                        if (r_cidx == last_idx) begin
                            n_count = last_idx;
                            n_ptr   = '0;
                            n_state = S_SCAN;
                        end else begin
                            n_ptr   = r_cidx + CNT_W'(1);
                            n_state = S_SHIFT_DN;
                        end
                    end else if (r_cidx == last_idx) begin
                        n_cv     = 1'b0;
                        n_status = ST_NOTFOUND;
                        n_ptr    = '0;
                        n_state  = S_SCAN;
                    end
                end
            end

            // move entries down one place over the removed one
            S_SHIFT_DN: begin
                rd_en      = 1'b1;
                n_mv_valid = 1'b1;
                n_mv_dst   = ADDR_W'(r_ptr - CNT_W'(1));
                if (r_ptr == last_idx) begin
                    n_count = last_idx;
                    n_ptr   = '0;
                    n_state = S_SCAN;
                end else begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end

            // find the first entry with the largest duration
            S_SCAN: begin
                if (!r_mv_valid && (r_ptr < r_count)) begin
                    rd_en  = 1'b1;
                    n_cv   = 1'b1;
                    n_cidx = r_ptr;
                    n_ptr  = r_ptr + CNT_W'(1);
                end
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else if (r_cv) begin
                    if ((r_cidx == '0) || (rd_dur > r_best_dur)) begin
                        n_best_idx = ADDR_W'(r_cidx);
                        n_best_id  = rd_id;
                        n_best_dur = rd_dur;
                    end
                    if (r_cidx == last_idx) begin
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_total    <= '0;
            r_mv_valid <= 1'b0;
            r_cv       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_total    <= n_total;
            r_mv_valid <= n_mv_valid;
            r_cv       <= n_cv;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_pos      <= n_pos;
        r_id       <= n_id;
        r_dur      <= n_dur;
        r_status   <= n_status;
        r_mv_dst   <= n_mv_dst;
        r_cidx     <= n_cidx;
        r_best_idx <= n_best_idx;
        r_best_id  <= n_best_id;
        r_best_dur <= n_best_dur;
    end

    // status and result
    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);

    assign o_res.status           = r_status;
    assign o_res.entry_count      = CNT_O_W'(r_count);
    assign o_res.total_duration   = r_total;
    assign o_res.longest_index    = IDX_O_W'(r_best_idx);
    assign o_res.longest_id       = ID_W'(r_best_id);
    assign o_res.longest_duration = DUR_W'(r_best_dur);

endmodule

>>> rtl/core/ordered_list_insert_remove_top.sv
// ============================================================================
// ordered_list_insert_remove_top: ordered list with insert and remove
// Keeps up to CAPACITY entries of identifier and duration in a memory.
// ============================================================================
// Usage:
//   i_in takes one operation item: insert at a position, or remove by
//   identifier. o_out returns one result item per operation: status, entry
//   count, total duration and the first entry with the largest duration.
//   Both channels are valid/ready; an item moves when both are high.
// Operation:
//   One operation at a time. The entry memory has one read and one write
//   port and moves one entry per cycle: an insert shifts the later entries
//   up and then writes the new entry, a remove searches for the match and
//   then shifts the later entries down, and every operation ends with a
//   scan for the longest entry and a done state. The result is registered
//   in the output register; the next item is taken once the engine is
//   back in idle.
// Reset:
//   Clears the count and the total; the entry memory needs no clearing.
// Stall:
//   The result sits in an output register; the next operation is taken
//   while it waits, and its own result holds in the engine until the
//   output register frees.
// ============================================================================
module ordered_list_insert_remove_top
    import ordlst_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ID_BITS       = ID_BITS_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ordlst_chan_if.sink   i_in,
    ordlst_chan_if.source o_out
);

    t_eng_stat eng_stat;
    t_out_item eng_res;
    t_in_item  in_item;
    logic      start;
    logic      take;
    logic      r_out_valid;
    t_out_item r_out_data;

    assign in_item     = i_in.data;
    assign i_in.ready  = eng_stat.idle;
    assign start       = i_in.valid && eng_stat.idle;
    assign take        = eng_stat.res_valid && (!r_out_valid || o_out.ready);

    ordlst_engine #(
        .CAPACITY      (CAPACITY),
        .ID_BITS       (ID_BITS),
        .DURATION_BITS (DURATION_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (in_item),
        .i_take  (take),
        .o_stat  (eng_stat),
        .o_res   (eng_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= eng_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule
